FILE: hdl/mcft_pkg.sv
// ----------------------------------------------------------------------------
// mcft_pkg
// Shared types and constants of the motor command frame transaction core.
// ----------------------------------------------------------------------------
package mcft_pkg;

  // Frame geometry
  localparam int FRAME_BYTES  = 10;
  localparam int REPLY_STORED = 9;

  localparam logic [3:0] FRAME_LAST_IDX  = 4'(FRAME_BYTES - 1);
  localparam logic [3:0] REPLY_LAST_IDX  = 4'(FRAME_BYTES - 1);
  localparam logic [3:0] REPLY_STORE_MAX = 4'(REPLY_STORED);

  // Function code checks
  localparam logic [7:0] FN_NIBBLE_MASK = 8'hF0;
  localparam logic [7:0] FN_WRITE_GROUP = 8'h50;
  localparam logic [7:0] FN_WRITE_STEP  = 8'h10;
  localparam logic [7:0] FN_READ_CODE   = 8'hA0;
  localparam logic [7:0] FN_BYTE_MASK   = 8'hFF;

  localparam logic [7:0] TIMEOUT_RESET = 8'd100;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Result kinds
  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_RX   = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TIMEOUT   = 3'd1,
    ST_STATION   = 3'd2,
    ST_FUNCTION  = 3'd3,
    ST_ADDR_HIGH = 3'd4,
    ST_ADDR_LOW  = 3'd5,
    ST_DEVICE    = 3'd6
  } status_t;

  // One unit of work for the back end: either a whole frame to stream, or a
  // single status result. For a status job, value carries the read value.
  typedef struct packed {
    logic        is_frame;
    logic [31:0] header;
    logic [31:0] value;
    logic [7:0]  checksum;
    status_t     status;
    logic [7:0]  device_error;
  } job_t;

endpackage

FILE: hdl/mcft_if.sv
// ----------------------------------------------------------------------------
// mcft_if
// Valid/ready channels of the core: command input and result output.
// ----------------------------------------------------------------------------
interface mcft_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  station_id;
  logic [7:0]  function_code;
  logic [7:0]  address_high;
  logic [7:0]  address_low;
  logic [31:0] command_value;
  logic [7:0]  rx_byte;

  modport source (
    output valid, op, station_id, function_code, address_high, address_low,
           command_value, rx_byte,
    input  ready
  );
  modport sink (
    input  valid, op, station_id, function_code, address_high, address_low,
           command_value, rx_byte,
    output ready
  );
endinterface

interface mcft_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [2:0]  status;
  logic [7:0]  device_error;
  logic [31:0] read_value;

  modport source (
    output valid, kind, tx_byte, last, status, device_error, read_value,
    input  ready
  );
  modport sink (
    input  valid, kind, tx_byte, last, status, device_error, read_value,
    output ready
  );
endinterface

FILE: hdl/mcft_front.sv
// ----------------------------------------------------------------------------
// mcft_front
// Accept transactions, track the reply wait and queue frame or status jobs.
// ----------------------------------------------------------------------------
module mcft_front (
  input  logic               clk,
  input  logic               rst,
  mcft_in_if.sink            in_ch,
  input  logic [7:0]         timeout_limit,
  output logic               q_push,
  output mcft_pkg::job_t     q_job,
  input  logic               q_full
);
  import mcft_pkg::*;

  logic [31:0] sent_header;
  logic [7:0]  reply_bytes [REPLY_STORED];
  logic [3:0]  reply_count;
  logic [7:0]  idle_ticks;
  logic        waiting;

  logic        accept;
  logic [7:0]  checksum;
  logic [7:0]  fn_sent;
  logic [7:0]  fn_expect;
  status_t     reply_status;
  logic        timed_out;
  logic        reply_done;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  assign checksum = in_ch.station_id + in_ch.function_code + in_ch.address_high
                  + in_ch.address_low + in_ch.command_value[31:24]
                  + in_ch.command_value[23:16] + in_ch.command_value[15:8]
                  + in_ch.command_value[7:0];

  assign fn_sent   = sent_header[23:16];
  assign fn_expect = (fn_sent + FN_WRITE_STEP) & FN_BYTE_MASK;

  // Reply check in priority order; all nine stored bytes are valid here
  always_comb begin
    if (reply_bytes[0] != sent_header[31:24]) begin
      reply_status = ST_STATION;
    end else if ((fn_sent & FN_NIBBLE_MASK) == FN_WRITE_GROUP
                 && reply_bytes[1] != fn_expect) begin
      reply_status = ST_FUNCTION;
    end else if (fn_sent == FN_READ_CODE
                 && (reply_bytes[1] & FN_NIBBLE_MASK) != FN_READ_CODE) begin
      reply_status = ST_FUNCTION;
    end else if (reply_bytes[2] != sent_header[15:8]) begin
      reply_status = ST_ADDR_HIGH;
    end else if (reply_bytes[3] != sent_header[7:0]) begin
      reply_status = ST_ADDR_LOW;
    end else if (reply_bytes[4] != 8'd0) begin
      reply_status = ST_DEVICE;
    end else begin
      reply_status = ST_OK;
    end
  end

  assign timed_out  = accept && waiting && op_t'(in_ch.op) == OP_TICK
                   && idle_ticks >= timeout_limit;
  assign reply_done = accept && waiting && op_t'(in_ch.op) == OP_RX
                   && reply_count == REPLY_LAST_IDX;

  always_comb begin
    q_push             = 1'b0;
    q_job.is_frame     = 1'b0;
    q_job.header       = {in_ch.station_id, in_ch.function_code,
                          in_ch.address_high, in_ch.address_low};
    q_job.value        = 32'd0;
    q_job.checksum     = checksum;
    q_job.status       = ST_OK;
    q_job.device_error = 8'd0;
    if (accept) begin
      unique case (op_t'(in_ch.op))
        OP_SEND: begin
          q_push         = 1'b1;
          q_job.is_frame = 1'b1;
          q_job.value    = in_ch.command_value;
        end
        OP_RX: begin
          if (reply_done) begin
            q_push       = 1'b1;
            q_job.status = reply_status;
            if (reply_status == ST_DEVICE) begin
              q_job.device_error = reply_bytes[4];
            end
            if (reply_status == ST_OK) begin
              q_job.value = {reply_bytes[5], reply_bytes[6],
                             reply_bytes[7], reply_bytes[8]};
            end
          end
        end
        OP_TICK: begin
          if (timed_out) begin
            q_push       = 1'b1;
            q_job.status = ST_TIMEOUT;
          end
        end
        default: begin
          q_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sent_header <= 32'd0;
      reply_count <= 4'd0;
      idle_ticks  <= 8'd0;
      waiting     <= 1'b0;
    end else if (accept) begin
      unique case (op_t'(in_ch.op))
        OP_SEND: begin
          sent_header <= {in_ch.station_id, in_ch.function_code,
                          in_ch.address_high, in_ch.address_low};
          reply_count <= 4'd0;
          idle_ticks  <= 8'd0;
          waiting     <= 1'b1;
        end
        OP_RX: begin
          if (waiting) begin
            idle_ticks <= 8'd0;
            if (reply_done) begin
              reply_count <= 4'd0;
              waiting     <= 1'b0;
            end else begin
              reply_count <= reply_count + 4'd1;
            end
          end
        end
        OP_TICK: begin
          if (waiting) begin
            if (timed_out) begin
              reply_count <= 4'd0;
              idle_ticks  <= 8'd0;
              waiting     <= 1'b0;
            end else begin
              idle_ticks <= idle_ticks + 8'd1;
            end
          end
        end
        default: begin
          waiting <= waiting;
        end
      endcase
    end
  end

  // Reply store: written in arrival order, read only once full
  always_ff @(posedge clk) begin
    if (accept && waiting && op_t'(in_ch.op) == OP_RX
        && reply_count < REPLY_STORE_MAX) begin
      reply_bytes[reply_count] <= in_ch.rx_byte;
    end
  end

  a_timeout_ends_wait: assert property (@(posedge clk) disable iff (rst)
    timed_out |=> !waiting && reply_count == 4'd0)
    else $error("timeout did not end the reply wait");

endmodule

FILE: hdl/mcft_queue.sv
// ----------------------------------------------------------------------------
// mcft_queue
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
module mcft_queue #(
  parameter int DEPTH = mcft_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mcft_pkg::job_t     push_job,
  output logic               full,
  input  logic               pop,
  output mcft_pkg::job_t     head_job,
  output logic               head_valid
);
  import mcft_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head_job   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("job pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && !head_valid))
    else $error("job popped from an empty queue");

endmodule

FILE: hdl/mcft_back.sv
// ----------------------------------------------------------------------------
// mcft_back
// Carry out queued jobs: stream frame bytes or issue one status result.
// ----------------------------------------------------------------------------
module mcft_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  mcft_pkg::job_t     q_job,
  output logic               q_pop,
  mcft_out_if.source         out_ch
);
  import mcft_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [3:0] idx;
  logic       out_load;
  logic       cur_last;
  logic [7:0] frame_byte;

  assign out_load = !out_ch.valid || out_ch.ready;
  assign cur_last = !cur.is_frame || idx == FRAME_LAST_IDX;
  assign q_pop    = q_valid && (!cur_valid || (out_load && cur_last));

  always_comb begin
    unique case (idx)
      4'd0:    frame_byte = cur.header[31:24];
      4'd1:    frame_byte = cur.header[23:16];
      4'd2:    frame_byte = cur.header[15:8];
      4'd3:    frame_byte = cur.header[7:0];
      4'd4:    frame_byte = 8'd0;
      4'd5:    frame_byte = cur.value[31:24];
      4'd6:    frame_byte = cur.value[23:16];
      4'd7:    frame_byte = cur.value[15:8];
      4'd8:    frame_byte = cur.value[7:0];
      4'd9:    frame_byte = cur.checksum;
      default: frame_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid    <= 1'b0;
      idx          <= 4'd0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_ch.valid <= cur_valid;
      end
      if (out_load && cur_valid) begin
        idx <= cur_last ? 4'd0 : idx + 4'd1;
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
      end else if (out_load && cur_valid && cur_last) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
    end
    if (out_load && cur_valid) begin
      if (cur.is_frame) begin
        out_ch.kind         <= KIND_TX;
        out_ch.tx_byte      <= frame_byte;
        out_ch.last         <= idx == FRAME_LAST_IDX;
        out_ch.status       <= ST_OK;
        out_ch.device_error <= 8'd0;
        out_ch.read_value   <= 32'd0;
      end else begin
        out_ch.kind         <= KIND_STATUS;
        out_ch.tx_byte      <= 8'd0;
        out_ch.last         <= 1'b0;
        out_ch.status       <= cur.status;
        out_ch.device_error <= cur.device_error;
        out_ch.read_value   <= cur.value;
      end
    end
  end

  a_idx_in_frame: assert property (@(posedge clk) disable iff (rst)
    cur_valid && cur.is_frame |-> idx <= FRAME_LAST_IDX)
    else $error("frame byte index ran past the checksum byte");

endmodule

FILE: hdl/motor_command_frame_transaction_core.sv
// ----------------------------------------------------------------------------
// motor_command_frame_transaction_core
// Motor command frame sender and reply checker with idle-tick timeout.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries three kinds of transaction, selected by op: send a command,
//   deliver a received serial byte, or signal a time tick. out_ch returns
//   transmit bytes (kind 0, last on the tenth) and transaction status results
//   (kind 1). cfg_write_en/cfg_write_data load timeout_limit; write it only
//   while idle, the block does not enforce this. Throughput: one input
//   transaction per cycle while the job queue has room; the back end drains
//   one result per cycle while out_ch accepts, so a command holds it for its
//   ten frame bytes and a status for one. QUEUE_DEPTH jobs may wait between.
//   Path: queue write, then back-end load, then output register.
//   Reset: synchronous; clears the wait, counters, queue and output valid,
//   and sets timeout_limit to 100. The reply store is not cleared.
//   Stall: when out_ch.ready is low the output register holds, the back end
//   stops, the queue fills and in_ch.ready drops only once it is full.
// ----------------------------------------------------------------------------
module motor_command_frame_transaction_core #(
  parameter int QUEUE_DEPTH = mcft_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  mcft_in_if.sink     in_ch,
  mcft_out_if.source  out_ch,
  input  logic        cfg_write_en,
  input  logic [7:0]  cfg_write_data
);
  import mcft_pkg::*;

  logic [7:0] timeout_limit;

  // Front to queue
  logic       q_push;
  job_t       q_push_job;
  logic       q_full;

  // Queue to back end
  logic       q_pop;
  job_t       q_head_job;
  logic       q_head_valid;

  // Hold the single configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_RESET;
    end else if (cfg_write_en) begin
      timeout_limit <= cfg_write_data;
    end
  end

  // Front: classify transactions, keep the reply wait, raise jobs
  mcft_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .timeout_limit (timeout_limit),
    .q_push        (q_push),
    .q_job         (q_push_job),
    .q_full        (q_full)
  );

  // Decouple the two halves so each can stall on its own
  mcft_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_job   (q_head_job),
    .head_valid (q_head_valid)
  );

  // Back: stream frame bytes and status results into the output register
  mcft_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_head_valid),
    .q_job   (q_head_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
